>>> sv/rdr_pkg.sv
`timescale 1ns / 1ps

package rdr_pkg;

  localparam int RING_SLOTS_DEFAULT = 16;
  localparam int SLOT_MAX_W = 8;

  localparam int LEN_W = 15;
  localparam int PKT_W = 16;
  localparam int WORD_W = 32;
  localparam int SEGS_W = 5;
  localparam int TRB_W = 8;
  localparam logic [TRB_W-1:0] TRB_RESET = 8'd16;
  localparam logic [SEGS_W-1:0] SEGS_MAX = 5'd31;
  localparam int TSA_BIT = 14;

  typedef enum logic [1:0] {
    ALLOC_OK = 2'd0,
    ALLOC_NO_REC = 2'd1,
    ALLOC_NO_BUF = 2'd2,
    ALLOC_BOTH = 2'd3
  } alloc_t;

  typedef enum logic [2:0] {
    ACT_WAIT = 3'd0,
    ACT_DROPPED = 3'd1,
    ACT_HELD = 3'd2,
    ACT_DELIVERED = 3'd3,
    ACT_TS_DELIVERED = 3'd4,
    ACT_ORPHAN = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DROP_REC,
    OP_DROP_BUF,
    OP_CTX,
    OP_SEG
  } op_t;

  typedef struct packed {
    op_t op;
    logic first;
    logic last;
    logic first_nc;
    logic tsa;
    logic [LEN_W-1:0] len;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } entry_t;

endpackage

>>> sv/rx_descriptor_reassembly_unit.sv
`timescale 1ns / 1ps
// Receive descriptor reassembly unit.
// Input channel (in_valid/in_ready) takes one written-back receive descriptor
// per item; the output channel (out_valid/out_ready) returns exactly one result
// item for each, in order: action, ring slot, segment offset and length, packet
// length, timestamp and the running packet, byte and drop counters.
// cfg_we/cfg_wdata write the timestamp record size; write only while idle.
// Each accepted item is first written into the descriptor queue and is then
// loaded into the result register when that register is empty or its result is taken.
// Throughput: one item per cycle while the receiver takes results; the result stage
// updates all reassembly state and counters for one descriptor together.
// When the receiver stalls, the result register holds, the two-entry queue
// fills and in_ready drops once it is full; no item is lost.
// Reset (rst, synchronous) empties the queue and result register, clears the
// ring slot, held packet state and counters, and sets the record size to 16.

module rx_descriptor_reassembly_unit #(
  parameter int RING_SLOTS = rdr_pkg::RING_SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rdr_pkg::TRB_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic owned_by_dma,
  input  logic first_desc,
  input  logic last_desc,
  input  logic context_desc,
  input  logic status1_valid,
  input  logic [rdr_pkg::LEN_W-1:0] cumulative_length,
  input  logic [rdr_pkg::WORD_W-1:0] desc_word0,
  input  logic [rdr_pkg::WORD_W-1:0] desc_word1,
  input  logic [1:0] alloc_status,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] action,
  output logic [3:0] slot_index,
  output logic [1:0] seg_offset,
  output logic [rdr_pkg::LEN_W-1:0] seg_length,
  output logic [rdr_pkg::PKT_W-1:0] packet_length,
  output logic [rdr_pkg::WORD_W-1:0] ts_seconds,
  output logic [rdr_pkg::WORD_W-1:0] ts_nanoseconds,
  output logic partial_discarded,
  output logic [rdr_pkg::WORD_W-1:0] packets_count,
  output logic [rdr_pkg::WORD_W-1:0] bytes_count,
  output logic [rdr_pkg::WORD_W-1:0] drops_count
);

  rdr_pkg::entry_t in_entry;
  rdr_pkg::entry_t q_head;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_ready = !q_full;

  rdr_front u_front (
    .owned_by_dma(owned_by_dma),
    .first_desc(first_desc),
    .last_desc(last_desc),
    .context_desc(context_desc),
    .status1_valid(status1_valid),
    .cumulative_length(cumulative_length),
    .desc_word0(desc_word0),
    .desc_word1(desc_word1),
    .alloc_status(alloc_status),
    .entry(in_entry)
  );

  rdr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_valid && in_ready),
    .push_entry(in_entry),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .head(q_head)
  );

  rdr_back #(
    .RING_SLOTS(RING_SLOTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action(action),
    .slot_index(slot_index),
    .seg_offset(seg_offset),
    .seg_length(seg_length),
    .packet_length(packet_length),
    .ts_seconds(ts_seconds),
    .ts_nanoseconds(ts_nanoseconds),
    .partial_discarded(partial_discarded),
    .packets_count(packets_count),
    .bytes_count(bytes_count),
    .drops_count(drops_count)
  );

endmodule

>>> sv/rdr_front.sv
`timescale 1ns / 1ps

module rdr_front (
  input  logic owned_by_dma,
  input  logic first_desc,
  input  logic last_desc,
  input  logic context_desc,
  input  logic status1_valid,
  input  logic [rdr_pkg::LEN_W-1:0] cumulative_length,
  input  logic [rdr_pkg::WORD_W-1:0] desc_word0,
  input  logic [rdr_pkg::WORD_W-1:0] desc_word1,
  input  logic [1:0] alloc_status,
  output rdr_pkg::entry_t entry
);

  rdr_pkg::alloc_t alloc;

  assign alloc = rdr_pkg::alloc_t'(alloc_status);

  always_comb begin
    entry.first = first_desc;
    entry.last = last_desc;
    entry.first_nc = !owned_by_dma && first_desc && !context_desc;
    entry.tsa = last_desc && status1_valid && desc_word1[rdr_pkg::TSA_BIT];
    entry.len = cumulative_length;
    entry.w0 = desc_word0;
    entry.w1 = desc_word1;
    if (owned_by_dma) begin
      entry.op = rdr_pkg::OP_WAIT;
    end else begin
      unique case (alloc) inside
        rdr_pkg::ALLOC_NO_REC, rdr_pkg::ALLOC_BOTH: entry.op = rdr_pkg::OP_DROP_REC;
        rdr_pkg::ALLOC_NO_BUF: entry.op = rdr_pkg::OP_DROP_BUF;
        default: entry.op = context_desc ? rdr_pkg::OP_CTX : rdr_pkg::OP_SEG;
      endcase
    end
  end

endmodule

>>> sv/rdr_queue.sv
`timescale 1ns / 1ps

module rdr_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rdr_pkg::entry_t push_entry,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output rdr_pkg::entry_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rdr_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/rdr_back.sv
`timescale 1ns / 1ps

module rdr_back #(
  parameter int RING_SLOTS = rdr_pkg::RING_SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rdr_pkg::TRB_W-1:0] cfg_wdata,
  input  logic q_valid,
  input  rdr_pkg::entry_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] action,
  output logic [3:0] slot_index,
  output logic [1:0] seg_offset,
  output logic [rdr_pkg::LEN_W-1:0] seg_length,
  output logic [rdr_pkg::PKT_W-1:0] packet_length,
  output logic [rdr_pkg::WORD_W-1:0] ts_seconds,
  output logic [rdr_pkg::WORD_W-1:0] ts_nanoseconds,
  output logic partial_discarded,
  output logic [rdr_pkg::WORD_W-1:0] packets_count,
  output logic [rdr_pkg::WORD_W-1:0] bytes_count,
  output logic [rdr_pkg::WORD_W-1:0] drops_count
);

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SLOT_MAX_W_LOCAL = rdr_pkg::SLOT_MAX_W;

  logic [rdr_pkg::TRB_W-1:0] trb;
  logic [SLOT_W-1:0] ring_slot;
  logic [SLOT_W-1:0] ring_slot_next;
  logic [rdr_pkg::SEGS_W-1:0] held_segments;
  logic [rdr_pkg::SEGS_W-1:0] held_segments_next;
  logic [rdr_pkg::LEN_W-1:0] held_length;
  logic [rdr_pkg::LEN_W-1:0] held_length_next;
  logic [rdr_pkg::LEN_W-1:0] held_packet_length;
  logic [rdr_pkg::LEN_W-1:0] held_packet_length_next;
  logic [rdr_pkg::WORD_W-1:0] packets_total;
  logic [rdr_pkg::WORD_W-1:0] packets_total_next;
  logic [rdr_pkg::WORD_W-1:0] bytes_total;
  logic [rdr_pkg::WORD_W-1:0] bytes_total_next;
  logic [rdr_pkg::WORD_W-1:0] drops_total;
  logic [rdr_pkg::WORD_W-1:0] drops_total_next;

  logic [rdr_pkg::SEGS_W-1:0] hs_eff;
  logic [rdr_pkg::LEN_W-1:0] hl_eff;
  logic [rdr_pkg::LEN_W-1:0] hpl_eff;
  logic [SLOT_MAX_W_LOCAL-1:0] slot_ext;

  rdr_pkg::act_t act_next;
  logic [1:0] offset_next;
  logic [rdr_pkg::LEN_W-1:0] seglen_next;
  logic [rdr_pkg::PKT_W-1:0] pktlen_next;
  logic [rdr_pkg::WORD_W-1:0] tss_next;
  logic [rdr_pkg::WORD_W-1:0] tsn_next;
  logic discarded_next;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign slot_ext = SLOT_MAX_W_LOCAL'(ring_slot);

  always_comb begin
    hs_eff = q_head.first_nc ? '0 : held_segments;
    hl_eff = q_head.first_nc ? '0 : held_length;
    hpl_eff = q_head.first_nc ? '0 : held_packet_length;
    ring_slot_next = (ring_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : ring_slot + 1'b1;
    held_segments_next = hs_eff;
    held_length_next = hl_eff;
    held_packet_length_next = hpl_eff;
    packets_total_next = packets_total;
    bytes_total_next = bytes_total;
    drops_total_next = drops_total;
    act_next = rdr_pkg::ACT_WAIT;
    offset_next = '0;
    seglen_next = '0;
    pktlen_next = '0;
    tss_next = '0;
    tsn_next = '0;
    discarded_next = q_head.first_nc && (held_segments != '0);
    unique case (q_head.op)
      rdr_pkg::OP_WAIT: begin
        ring_slot_next = ring_slot;
        held_segments_next = held_segments;
        held_length_next = held_length;
        held_packet_length_next = held_packet_length;
        discarded_next = 1'b0;
      end
      rdr_pkg::OP_DROP_REC: begin
        act_next = rdr_pkg::ACT_DROPPED;
      end
      rdr_pkg::OP_DROP_BUF: begin
        act_next = rdr_pkg::ACT_DROPPED;
        drops_total_next = drops_total + 1'b1;
      end
      rdr_pkg::OP_CTX: begin
        if (hs_eff != '0) begin
          act_next = rdr_pkg::ACT_TS_DELIVERED;
          seglen_next = rdr_pkg::LEN_W'(trb);
          pktlen_next = rdr_pkg::PKT_W'(hpl_eff) + rdr_pkg::PKT_W'(trb);
          tss_next = q_head.w1;
          tsn_next = q_head.w0;
          packets_total_next = packets_total + 1'b1;
          bytes_total_next = bytes_total + rdr_pkg::WORD_W'(hpl_eff);
          held_segments_next = '0;
          held_packet_length_next = '0;
        end else begin
          act_next = rdr_pkg::ACT_ORPHAN;
        end
      end
      rdr_pkg::OP_SEG: begin
        offset_next = q_head.first ? 2'd2 : 2'd0;
        if (q_head.first && q_head.last && !q_head.tsa) begin
          act_next = rdr_pkg::ACT_DELIVERED;
          seglen_next = q_head.len;
          pktlen_next = rdr_pkg::PKT_W'(q_head.len);
          packets_total_next = packets_total + 1'b1;
          bytes_total_next = bytes_total + rdr_pkg::WORD_W'(q_head.len);
        end else begin
          held_segments_next = (hs_eff == rdr_pkg::SEGS_MAX) ? hs_eff : hs_eff + 1'b1;
          seglen_next = q_head.len - hl_eff;
          act_next = rdr_pkg::ACT_HELD;
          if (q_head.last) begin
            held_packet_length_next = q_head.len;
            if (!q_head.tsa) begin
              act_next = rdr_pkg::ACT_DELIVERED;
              pktlen_next = rdr_pkg::PKT_W'(q_head.len);
              packets_total_next = packets_total + 1'b1;
              bytes_total_next = bytes_total + rdr_pkg::WORD_W'(q_head.len);
              held_segments_next = '0;
              held_packet_length_next = '0;
            end
          end else begin
            held_length_next = q_head.len;
          end
        end
      end
      default: begin
        ring_slot_next = ring_slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trb <= rdr_pkg::TRB_RESET;
    end else if (cfg_we) begin
      trb <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_slot <= '0;
      held_segments <= '0;
      held_length <= '0;
      held_packet_length <= '0;
      packets_total <= '0;
      bytes_total <= '0;
      drops_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        ring_slot <= ring_slot_next;
        held_segments <= held_segments_next;
        held_length <= held_length_next;
        held_packet_length <= held_packet_length_next;
        packets_total <= packets_total_next;
        bytes_total <= bytes_total_next;
        drops_total <= drops_total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      action <= act_next;
      slot_index <= slot_ext[3:0];
      seg_offset <= offset_next;
      seg_length <= seglen_next;
      packet_length <= pktlen_next;
      ts_seconds <= tss_next;
      ts_nanoseconds <= tsn_next;
      partial_discarded <= discarded_next;
      packets_count <= packets_total_next;
      bytes_count <= bytes_total_next;
      drops_count <= drops_total_next;
    end
  end

endmodule

>>> sv/rdr_checker.sv
`timescale 1ns / 1ps

module rdr_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] action,
  input logic [1:0] seg_offset,
  input logic [rdr_pkg::LEN_W-1:0] seg_length,
  input logic [rdr_pkg::PKT_W-1:0] packet_length,
  input logic [rdr_pkg::WORD_W-1:0] ts_seconds,
  input logic [rdr_pkg::WORD_W-1:0] packets_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(packets_count))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_wait_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == rdr_pkg::ACT_WAIT |->
      seg_length == '0 && packet_length == '0 && seg_offset == '0)
    else $error("wait result carries data");

  a_len_only_delivered: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != rdr_pkg::ACT_DELIVERED && action != rdr_pkg::ACT_TS_DELIVERED |->
      packet_length == '0)
    else $error("packet length on non-delivery");

  a_ts_only_stamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != rdr_pkg::ACT_TS_DELIVERED |-> ts_seconds == '0)
    else $error("timestamp on non-stamped result");

endmodule

bind rx_descriptor_reassembly_unit rdr_checker u_rdr_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .action(action),
  .seg_offset(seg_offset),
  .seg_length(seg_length),
  .packet_length(packet_length),
  .ts_seconds(ts_seconds),
  .packets_count(packets_count)
);
